@@ hw/rtl/lmb_pkg.sv @@
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared defaults, types and the arctangent table for the bearing pipeline.
// ----------------------------------------------------------------------------
package lmb_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC angle accumulator: 2^31 stands for pi, wraps modulo 2^32
  localparam int          ACC_WIDTH = 32;
  localparam logic [31:0] ACC_PI    = 32'h8000_0000;

  // control bits that travel with each pipeline transaction
  typedef struct packed {
    logic valid;
    logic zero;   // both offsets are zero: the arctangent is exactly 0
  } lmb_ctrl_t;

  // atan(2^-i) in accumulator units, rounded to nearest
  function automatic logic [ACC_WIDTH-1:0] atan_entry(input logic [4:0] idx);
    logic [ACC_WIDTH-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      5'd30:   val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/lmb_prep.sv @@
// ----------------------------------------------------------------------------
// lmb_prep
// Two front stages: form the offsets, then fold the left half-plane onto the
// right by turning the vector through pi.
// ----------------------------------------------------------------------------
module lmb_prep #(
  parameter int COORD_WIDTH = lmb_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = lmb_pkg::ANGLE_WIDTH_DEF,
  parameter int XW          = COORD_WIDTH + 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [COORD_WIDTH-1:0]     in_landmark_x,
  input  logic signed [COORD_WIDTH-1:0]     in_landmark_y,
  input  logic signed [COORD_WIDTH-1:0]     in_robot_x,
  input  logic signed [COORD_WIDTH-1:0]     in_robot_y,
  input  logic        [ANGLE_WIDTH-1:0]     in_robot_heading,
  output lmb_pkg::lmb_ctrl_t                out_ctrl,
  output logic signed [XW-1:0]              out_x,
  output logic signed [XW-1:0]              out_y,
  output logic        [lmb_pkg::ACC_WIDTH-1:0] out_z,
  output logic        [ANGLE_WIDTH-1:0]     out_head
);

  localparam int DW = COORD_WIDTH + 1;

  logic                   a_valid_r;
  logic signed [DW-1:0]   dx_r, dy_r;
  logic signed [DW-1:0]   dx_nxt, dy_nxt;
  logic [ANGLE_WIDTH-1:0] a_head_r;

  lmb_pkg::lmb_ctrl_t                b_ctrl_r, b_ctrl_nxt;
  logic signed [XW-1:0]              b_x_r, b_y_r, b_x_nxt, b_y_nxt;
  logic signed [XW-1:0]              x_ext, y_ext;
  logic [lmb_pkg::ACC_WIDTH-1:0]     b_z_r, b_z_nxt;
  logic [ANGLE_WIDTH-1:0]            b_head_r;

  // offsets at one extra bit so that they never overflow
  assign dx_nxt = DW'(in_landmark_x) - DW'(in_robot_x);
  assign dy_nxt = DW'(in_landmark_y) - DW'(in_robot_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    a_head_r <= in_robot_heading;
  end

  // fold: a vector pointing left is negated and starts at pi
  assign x_ext = XW'(dx_r);
  assign y_ext = XW'(dy_r);

  always_comb begin
    b_ctrl_nxt.valid = a_valid_r;
    b_ctrl_nxt.zero  = (dx_r == '0) && (dy_r == '0);
    if (dx_r[DW-1]) begin
      b_x_nxt = -x_ext;
      b_y_nxt = -y_ext;
      b_z_nxt = lmb_pkg::ACC_PI;
    end else begin
      b_x_nxt = x_ext;
      b_y_nxt = y_ext;
      b_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctrl_r <= '0;
    end else begin
      b_ctrl_r <= b_ctrl_nxt;
    end
    b_x_r    <= b_x_nxt;
    b_y_r    <= b_y_nxt;
    b_z_r    <= b_z_nxt;
    b_head_r <= a_head_r;
  end

  assign out_ctrl = b_ctrl_r;
  assign out_x    = b_x_r;
  assign out_y    = b_y_r;
  assign out_z    = b_z_r;
  assign out_head = b_head_r;

endmodule

@@ hw/rtl/lmb_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// lmb_cordic_stage
// One registered vectoring iteration: rotate towards the x axis by
// atan(2^-STAGE) and accumulate the angle.
// ----------------------------------------------------------------------------
module lmb_cordic_stage #(
  parameter int XW          = 20,
  parameter int ANGLE_WIDTH = lmb_pkg::ANGLE_WIDTH_DEF,
  parameter int STAGE       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lmb_pkg::lmb_ctrl_t                   in_ctrl,
  input  logic signed [XW-1:0]                 in_x,
  input  logic signed [XW-1:0]                 in_y,
  input  logic        [lmb_pkg::ACC_WIDTH-1:0] in_z,
  input  logic        [ANGLE_WIDTH-1:0]        in_head,
  output lmb_pkg::lmb_ctrl_t                   out_ctrl,
  output logic signed [XW-1:0]                 out_x,
  output logic signed [XW-1:0]                 out_y,
  output logic        [lmb_pkg::ACC_WIDTH-1:0] out_z,
  output logic        [ANGLE_WIDTH-1:0]        out_head
);

  localparam logic [lmb_pkg::ACC_WIDTH-1:0] ANGLE = lmb_pkg::atan_entry(5'(STAGE));

  lmb_pkg::lmb_ctrl_t                ctrl_r;
  logic signed [XW-1:0]              x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic [lmb_pkg::ACC_WIDTH-1:0]     z_r, z_nxt;
  logic [ANGLE_WIDTH-1:0]            head_r;

  assign xs = in_x >>> STAGE;
  assign ys = in_y >>> STAGE;

  // rotate down while y is positive, up otherwise
  always_comb begin
    if (in_y > 0) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ANGLE;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= in_ctrl;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    head_r <= in_head;
  end

  assign out_ctrl = ctrl_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_z    = z_r;
  assign out_head = head_r;

endmodule

@@ hw/rtl/lmb_post.sv @@
// ----------------------------------------------------------------------------
// lmb_post
// Output stage: round the accumulated angle to the output width, subtract
// the heading and wrap.
// ----------------------------------------------------------------------------
module lmb_post #(
  parameter int ANGLE_WIDTH = lmb_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lmb_pkg::lmb_ctrl_t                   in_ctrl,
  input  logic        [lmb_pkg::ACC_WIDTH-1:0] in_z,
  input  logic        [ANGLE_WIDTH-1:0]        in_head,
  output logic                                 out_valid,
  output logic signed [ANGLE_WIDTH-1:0]        out_bearing
);

  localparam int SH = lmb_pkg::ACC_WIDTH - ANGLE_WIDTH;

  logic [lmb_pkg::ACC_WIDTH-1:0] z_use;
  logic [ANGLE_WIDTH-1:0]        angle;
  logic                          valid_r;
  logic [ANGLE_WIDTH-1:0]        bearing_r, bearing_nxt;

  // coincident points give exactly zero
  assign z_use = in_ctrl.zero ? '0 : in_z;

  // round to nearest, ties up; a carry into pi wraps to -pi
  generate
    if (SH > 0) begin : g_round
      logic [lmb_pkg::ACC_WIDTH:0] sum;
      assign sum   = {1'b0, z_use} + ((lmb_pkg::ACC_WIDTH+1)'(1) << (SH - 1));
      assign angle = sum[lmb_pkg::ACC_WIDTH-1:SH];
    end else begin : g_plain
      assign angle = z_use[ANGLE_WIDTH-1:0];
    end
  endgenerate

  assign bearing_nxt = angle - in_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_ctrl.valid;
    end
    bearing_r <= bearing_nxt;
  end

  assign out_valid   = valid_r;
  assign out_bearing = bearing_r;

endmodule

@@ hw/rtl/landmark_bearing.sv @@
// An accepted start passes to the out_valid strobe through the whole pipeline
// (two front stages, one per CORDIC iteration, one output stage).
// Throughput: one transaction per cycle; busy is low whenever reset is released.
// The receiver cannot stall, so each result shows for exactly one cycle.
// Reset (synchronous, active low) clears every valid bit; in-flight work is dropped.
// ----------------------------------------------------------------------------
// landmark_bearing
// Relative bearing of a landmark seen from a robot, via a pipelined CORDIC.
// ----------------------------------------------------------------------------
module landmark_bearing #(
  parameter int COORD_WIDTH   = lmb_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = lmb_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = lmb_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_landmark_x,
  input  logic signed [COORD_WIDTH-1:0] in_landmark_y,
  input  logic signed [COORD_WIDTH-1:0] in_robot_x,
  input  logic signed [COORD_WIDTH-1:0] in_robot_y,
  input  logic signed [ANGLE_WIDTH-1:0] in_robot_heading,
  output logic                          out_valid,
  output logic signed [ANGLE_WIDTH-1:0] out_bearing
);

  // headroom for the CORDIC gain on top of the folded offset
  localparam int XW = COORD_WIDTH + 4;

  lmb_pkg::lmb_ctrl_t                ctrl  [0:CORDIC_STAGES];
  logic signed [XW-1:0]              cx    [0:CORDIC_STAGES];
  logic signed [XW-1:0]              cy    [0:CORDIC_STAGES];
  logic [lmb_pkg::ACC_WIDTH-1:0]     cz    [0:CORDIC_STAGES];
  logic [ANGLE_WIDTH-1:0]            chead [0:CORDIC_STAGES];

  // accept whenever out of reset
  assign busy = ~rst_n;

  lmb_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .XW          (XW)
  ) u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (start & ~busy),
    .in_landmark_x    (in_landmark_x),
    .in_landmark_y    (in_landmark_y),
    .in_robot_x       (in_robot_x),
    .in_robot_y       (in_robot_y),
    .in_robot_heading (in_robot_heading),
    .out_ctrl         (ctrl[0]),
    .out_x            (cx[0]),
    .out_y            (cy[0]),
    .out_z            (cz[0]),
    .out_head         (chead[0])
  );

  // chain of vectoring iterations
  generate
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      lmb_cordic_stage #(
        .XW          (XW),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .STAGE       (i)
      ) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (ctrl[i]),
        .in_x     (cx[i]),
        .in_y     (cy[i]),
        .in_z     (cz[i]),
        .in_head  (chead[i]),
        .out_ctrl (ctrl[i+1]),
        .out_x    (cx[i+1]),
        .out_y    (cy[i+1]),
        .out_z    (cz[i+1]),
        .out_head (chead[i+1])
      );
    end
  endgenerate

  lmb_post #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ctrl     (ctrl[CORDIC_STAGES]),
    .in_z        (cz[CORDIC_STAGES]),
    .in_head     (chead[CORDIC_STAGES]),
    .out_valid   (out_valid),
    .out_bearing (out_bearing)
  );

endmodule

@@ hw/rtl/lmb_checker.sv @@
// ----------------------------------------------------------------------------
// lmb_checker
// Port-level checks of the bearing pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module lmb_checker #(
  parameter int COORD_WIDTH   = lmb_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = lmb_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = lmb_pkg::CORDIC_STAGES_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] in_landmark_x,
  input logic signed [COORD_WIDTH-1:0] in_landmark_y,
  input logic signed [COORD_WIDTH-1:0] in_robot_x,
  input logic signed [COORD_WIDTH-1:0] in_robot_y,
  input logic signed [ANGLE_WIDTH-1:0] in_robot_heading,
  input logic                          out_valid,
  input logic signed [ANGLE_WIDTH-1:0] out_bearing
);

  localparam int LAT = CORDIC_STAGES + 3;

  logic accept;
  logic coincide;

  assign accept   = start && !busy;
  assign coincide = (in_landmark_x == in_robot_x) && (in_landmark_y == in_robot_y);

  // every accepted transaction yields a strobe a fixed latency later
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted transaction produced no result");

  // no strobe without a transaction accepted a fixed latency earlier
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without an accepted transaction");

  // coincident points give a bearing of minus the heading
  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && coincide, LAT)) |->
      (out_bearing == ANGLE_WIDTH'(-$past(in_robot_heading, LAT))))
    else $error("coincident points did not give minus the heading");

  // no transaction can be taken while reset holds
  a_busy_in_reset: assert property (@(posedge clk)
    !rst_n |-> busy)
    else $error("block ready while in reset");

endmodule

bind landmark_bearing lmb_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .ANGLE_WIDTH   (ANGLE_WIDTH),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_lmb_checker (.*);
